// File: rtl/sfla_pkg.sv
// Package for the slot free-list allocator: widths, operation and status codes,
// the controller state type and the command and status structs.
// It depends on nothing else and is compiled first.
package sfla_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int KIND_W         = 2;
    localparam int KEY_W          = 16;
    localparam int STATUS_W       = 2;
    localparam int ID_W           = 11;

    typedef enum logic [KIND_W-1:0] {
        OP_ALLOC    = 2'd0,
        OP_QUERY    = 2'd1,
        OP_FREE     = 2'd2,
        OP_FREE_ALL = 2'd3
    } t_op_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RANGE    = 2'd2,
        ST_INACTIVE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FREE_ALL,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic fa_step;
        logic clr_step;
        logic load_out;
        logic hold_sel;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic walk_last;
    } t_stat;

endpackage

// File: rtl/sfla_ctrl.sv
// Controller of the slot free-list allocator: a state machine that sequences
// the clearing pass, single operations, the free-all walk and result hand-off.
// Depends on sfla_pkg.
module sfla_ctrl
    import sfla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  t_stat             i_stat,
    output logic              o_in_stall,
    output t_cmd              o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.walk_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_op_kind'(i_kind) == OP_FREE_ALL) ? S_FREE_ALL : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.out_free ? S_IDLE : S_HOLD;
            end
            S_FREE_ALL: begin
                if (i_stat.walk_last) n_state = i_stat.out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != S_IDLE);
        o_cmd.accept     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.fa_step    = (r_state == S_FREE_ALL);
        o_cmd.clr_step   = (r_state == S_CLEAR);
        o_cmd.hold_sel   = (r_state == S_HOLD);
        o_cmd.load_out   = i_stat.out_free &&
                           ((r_state == S_EXEC) || (r_state == S_HOLD) ||
                            ((r_state == S_FREE_ALL) && i_stat.walk_last));
    end

endmodule

// File: rtl/sfla_datapath.sv
// Datapath of the slot free-list allocator: the link and active-bit memory,
// head and walk registers, result logic and the output register.
// Depends on sfla_pkg; driven by sfla_ctrl commands.
module sfla_datapath
    import sfla_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [KEY_W-1:0]    i_key_id,
    input  logic                i_out_stall,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_new_id
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WORD_W = IDX_W + 2;
    localparam int ACT_B  = IDX_W + 1;
    localparam int VLD_B  = IDX_W;

    // Each word holds the active bit, the link valid bit and the link itself.
    logic [WORD_W-1:0] r_mem [SLOT_COUNT];
    logic [WORD_W-1:0] r_rd_word;

    logic [IDX_W-1:0]    r_head;
    logic                r_head_vld;
    logic [IDX_W-1:0]    r_walk;
    logic [IDX_W-1:0]    r_idx;
    t_op_kind            r_kind;
    logic                r_bad;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ID_W-1:0]     r_out_new_id;
    t_status             r_pend_status;
    logic [ID_W-1:0]     r_pend_new_id;

    logic [IDX_W-1:0]  n_head;
    logic              n_head_vld;
    logic [IDX_W-1:0]  n_walk;
    logic              n_out_valid;

    logic              walk_last;
    logic [KEY_W-1:0]  key_m1;
    logic              key_bad;
    t_op_kind          in_kind;
    logic [IDX_W-1:0]  in_idx;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_active;
    t_status           res_status;
    logic [ID_W-1:0]   res_new_id;

    assign walk_last = (r_walk == IDX_W'(SLOT_COUNT - 1));
    assign in_kind   = t_op_kind'(i_kind);
    assign key_m1    = i_key_id - KEY_W'(1);
    assign key_bad   = (i_key_id == '0) || (i_key_id > KEY_W'(SLOT_COUNT));
    assign in_idx    = (in_kind == OP_ALLOC) ? r_head : key_m1[IDX_W-1:0];
    assign rd_active = r_rd_word[ACT_B];

    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.walk_last = walk_last;

    // Read port: the item's slot at acceptance, the next slot during the walk.
    always_comb begin
        rd_en   = i_cmd.accept || i_cmd.fa_step;
        rd_addr = i_cmd.fa_step ? IDX_W'(r_walk + IDX_W'(1)) :
                  (in_kind == OP_FREE_ALL) ? '0 : in_idx;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_word <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = {1'b0, r_head_vld, r_head};
        n_head     = r_head;
        n_head_vld = r_head_vld;
        res_status = ST_OK;
        res_new_id = '0;
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_walk;
            wr_data = {1'b0, !walk_last, IDX_W'(r_walk + IDX_W'(1))};
        end else if (i_cmd.fa_step) begin
            wr_addr = r_walk;
            if (rd_active) begin
                wr_en      = 1'b1;
                n_head     = r_walk;
                n_head_vld = 1'b1;
            end
        end else if (i_cmd.exec) begin
            unique case (r_kind)
                OP_ALLOC: begin
                    if (r_bad) begin
                        res_status = ST_EMPTY;
                    end else begin
                        res_new_id = ID_W'(r_idx) + ID_W'(1);
                        wr_en      = 1'b1;
                        wr_data    = {1'b1, 1'b0, {IDX_W{1'b0}}};
                        n_head     = r_rd_word[IDX_W-1:0];
                        n_head_vld = r_rd_word[VLD_B];
                    end
                end
                OP_QUERY, OP_FREE: begin
                    if (r_bad) begin
                        res_status = ST_RANGE;
                    end else if (!rd_active) begin
                        res_status = ST_INACTIVE;
                    end else if (r_kind == OP_FREE) begin
                        wr_en      = 1'b1;
                        n_head     = r_idx;
                        n_head_vld = 1'b1;
                    end
                end
                OP_FREE_ALL: res_status = ST_OK;
                default:     res_status = ST_OK;
            endcase
        end
    end

    always_comb begin
        n_walk = r_walk;
        if (i_cmd.clr_step || i_cmd.fa_step) begin
            n_walk = walk_last ? '0 : IDX_W'(r_walk + IDX_W'(1));
        end else if (i_cmd.accept) begin
            n_walk = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.load_out) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_head_vld  <= 1'b1;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_head_vld  <= n_head_vld;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= in_kind;
            r_idx  <= in_idx;
            r_bad  <= (in_kind == OP_ALLOC) ? !r_head_vld : key_bad;
        end
        if (i_cmd.exec || i_cmd.fa_step) begin
            r_pend_status <= res_status;
            r_pend_new_id <= res_new_id;
        end
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.hold_sel ? r_pend_status : res_status;
            r_out_new_id <= i_cmd.hold_sel ? r_pend_new_id : res_new_id;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_new_id    = r_out_new_id;

endmodule

// File: rtl/slot_free_list_allocator_unit.sv
// Top level of the slot free-list allocator: joins the controller and the datapath.
// Depends on sfla_pkg, sfla_ctrl and sfla_datapath.
//
// Usage: each request on the input channel carries an operation (alloc, query,
// free or free all) and a 1-based key id; each request yields exactly one
// result with a status code and, for a successful alloc, the new 1-based id.
// Both channels use valid and stall; a request is taken on a clock edge where
// its valid is high and its stall is low.
// Alloc, query and free each first read the slot's link and active bit from
// the slot memory, then update it and produce the result.
// Free all walks the whole pool one slot per cycle on the memory's read
// and write ports.
// The result lands in an output register, so a new request is accepted while
// the previous result is still waiting. If the receiver stalls and the output
// register is still full when the next result is ready, the result is parked
// and the input stays stalled until the output register frees up.
// After reset the slot memory is initialized by a clearing pass over every slot
// (link i points to i+1, every slot inactive) during which the input
// channel is stalled; the free list head starts at slot 0.
module slot_free_list_allocator_unit
    import sfla_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [KEY_W-1:0]    i_key_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_new_id
);

    // Commands flow from the controller, status flows back from the datapath.
    t_cmd  cmd;
    t_stat stat;

    sfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sfla_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_kind),
        .i_key_id    (i_key_id),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_new_id    (o_new_id)
    );

endmodule

// File: rtl/sfla_checker.sv
// Port-level checker for the slot free-list allocator, bound to the top level.
// Depends on sfla_pkg and slot_free_list_allocator_unit.
module sfla_checker
    import sfla_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [ID_W-1:0]     o_new_id
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_new_id))
        else $error("stalled result changed");

    // Reset starts the clearing pass, so no request is taken right after it.
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // Every accepted request leaves the block busy, with the input stalled.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted on back-to-back cycles");

    // A nonzero id only comes with an ok status and lies within the pool.
    a_id_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_new_id != '0) |->
            (o_status == ST_OK) && (o_new_id <= ID_W'(SLOT_COUNT)))
        else $error("bad allocated id");

endmodule

bind slot_free_list_allocator_unit sfla_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_sfla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_new_id    (o_new_id)
);
